// File: src/mrmg_pkg.sv
package mrmg_pkg;

  localparam int unsigned SIDE_MAX = 63;
  localparam int unsigned COORD_W  = 6;
  localparam int unsigned ADDR_W   = 2 * COORD_W;
  localparam int unsigned LABEL_W  = 10;
  localparam int unsigned DEPTH    = 1 << ADDR_W;

  typedef enum logic [1:0] {
    OP_PREPARE = 2'd0,
    OP_TRY     = 2'd1,
    OP_READ    = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_MERGE = 2'd1,
    STAT_BAD      = 2'd2,
    STAT_FINISHED = 2'd3
  } status_e;

  // memory request from the sequencer, one read and one write per cycle
  typedef struct packed {
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [LABEL_W-1:0] wdata;
    logic [ADDR_W-1:0]  raddr;
  } mem_req_t;

  typedef struct packed {
    status_e            status;
    logic [LABEL_W-1:0] label;
    logic [LABEL_W-1:0] regions;
    logic               finished;
  } result_t;

endpackage

// File: src/mrmg_grid_mem.sv
module mrmg_grid_mem (
  input  logic                        clk_i,
  input  mrmg_pkg::mem_req_t          req_i,
  output logic [mrmg_pkg::LABEL_W-1:0] rdata_o
);

  logic [mrmg_pkg::LABEL_W-1:0] mem [mrmg_pkg::DEPTH];
  logic [mrmg_pkg::LABEL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/mrmg_ctrl.sv
module mrmg_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mrmg_pkg::COORD_W-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    operation_i,
  input  logic [mrmg_pkg::COORD_W-1:0]  row_i,
  input  logic [mrmg_pkg::COORD_W-1:0]  col_i,
  output mrmg_pkg::mem_req_t            mem_req_o,
  input  logic [mrmg_pkg::LABEL_W-1:0]  mem_rdata_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output mrmg_pkg::result_t             res_o
);

  localparam int unsigned CW = mrmg_pkg::COORD_W;
  localparam int unsigned LW = mrmg_pkg::LABEL_W;
  localparam int unsigned HW = CW - 1;

  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_TRY_RD, S_TRY_CHK, S_REL, S_FIN_RD, S_FIN_CHK, S_RESULT
  } state_e;

  state_e state_q, state_d;
  logic [1:0]   op_q, op_d;
  logic [CW-1:0] row_q, row_d, col_q, col_d;
  logic [CW-1:0] r_q, r_d, c_q, c_d;
  logic [CW-1:0] side_q, side_d, grid_side_q, grid_side_d;
  logic [2:0]   k_q, k_d;
  logic [LW-1:0] first_q, first_d, old_q, old_d, next_q, next_d;
  logic [LW-1:0] cnt_q, cnt_d, label_q, label_d;
  logic         issue_q, issue_d, pend_q, pend_d, ready_q, ready_d;
  logic [mrmg_pkg::ADDR_W-1:0] pend_addr_q, pend_addr_d;
  mrmg_pkg::status_e status_q, status_d;

  logic          accept;
  logic          side_bad, outside, in_grid, last_col, last_row;
  logic [HW-1:0] half;
  logic [CW-1:0] nr, nc;
  logic [LW-1:0] v;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign side_bad = (grid_side_q < CW'(3)) || !grid_side_q[0] ||
                    ({1'b0, grid_side_q} > (CW + 1)'(mrmg_pkg::SIDE_MAX));
  assign outside  = (row_i == '0) || (col_i == '0) ||
                    ({1'b0, row_i} + 7'd1 >= {1'b0, side_q}) ||
                    ({1'b0, col_i} + 7'd1 >= {1'b0, side_q});
  assign in_grid  = ready_q && (row_q < side_q) && (col_q < side_q);
  assign last_col = (c_q == side_q - CW'(1));
  assign last_row = (r_q == side_q - CW'(1));
  assign half     = side_q[CW-1:1];
  assign v        = mem_rdata_i;

  // neighbor order: down, up, right, left; k of zero is the cell itself
  always_comb begin
    nr = row_q;
    nc = col_q;
    case (k_q)
      3'd1:    nr = row_q + CW'(1);
      3'd2:    nr = row_q - CW'(1);
      3'd3:    nc = col_q + CW'(1);
      3'd4:    nc = col_q - CW'(1);
      default: ;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    row_d       = row_q;
    col_d       = col_q;
    r_d         = r_q;
    c_d         = c_q;
    side_d      = side_q;
    grid_side_d = grid_side_q;
    k_d         = k_q;
    first_d     = first_q;
    old_d       = old_q;
    next_d      = next_q;
    cnt_d       = cnt_q;
    label_d     = label_q;
    issue_d     = issue_q;
    pend_d      = pend_q;
    pend_addr_d = pend_addr_q;
    ready_d     = ready_q;
    status_d    = status_q;
    mem_req_o.we    = 1'b0;
    mem_req_o.waddr = {r_q, c_q};
    mem_req_o.wdata = '0;
    mem_req_o.raddr = {row_q, col_q};

    if (cfg_we_i) begin
      grid_side_d = cfg_wdata_i;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d  = operation_i;
          row_d = row_i;
          col_d = col_i;
          state_d = S_FIN_RD;
          case (operation_i)
            mrmg_pkg::OP_PREPARE: begin
              if (side_bad) begin
                status_d = mrmg_pkg::STAT_BAD;
              end else begin
                side_d  = grid_side_q;
                r_d     = '0;
                c_d     = '0;
                next_d  = LW'(1);
                state_d = S_PREP;
              end
            end
            mrmg_pkg::OP_TRY: begin
              if (!ready_q) begin
                status_d = mrmg_pkg::STAT_BAD;
              end else if (cnt_q <= LW'(1)) begin
                status_d = mrmg_pkg::STAT_FINISHED;
              end else if (outside) begin
                status_d = mrmg_pkg::STAT_BAD;
              end else begin
                k_d     = '0;
                first_d = '0;
                state_d = S_TRY_RD;
              end
            end
            mrmg_pkg::OP_READ: status_d = mrmg_pkg::STAT_OK;
            default:           status_d = mrmg_pkg::STAT_BAD;
          endcase
        end
      end
      S_PREP: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = {r_q, c_q};
        // rooms sit at odd row and odd column
        if (r_q[0] && c_q[0]) begin
          mem_req_o.wdata = next_q;
          next_d = next_q + LW'(1);
        end
        if (last_col) begin
          c_d = '0;
          if (last_row) begin
            cnt_d    = LW'({5'd0, half} * {5'd0, half});
            ready_d  = 1'b1;
            status_d = mrmg_pkg::STAT_OK;
            state_d  = S_FIN_RD;
          end else begin
            r_d = r_q + CW'(1);
          end
        end else begin
          c_d = c_q + CW'(1);
        end
      end
      S_TRY_RD: begin
        mem_req_o.raddr = {nr, nc};
        state_d = S_TRY_CHK;
      end
      S_TRY_CHK: begin
        if (k_q == 3'd0) begin
          if (v != '0) begin
            status_d = mrmg_pkg::STAT_NO_MERGE;
            state_d  = S_FIN_RD;
          end else begin
            k_d     = 3'd1;
            state_d = S_TRY_RD;
          end
        end else if (v == '0 || first_q == '0 || first_q == v) begin
          if (v != '0) begin
            first_d = v;
          end
          if (k_q == 3'd4) begin
            status_d = mrmg_pkg::STAT_NO_MERGE;
            state_d  = S_FIN_RD;
          end else begin
            k_d     = k_q + 3'd1;
            state_d = S_TRY_RD;
          end
        end else begin
          // open the wall, then sweep the grid for the second region
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = {row_q, col_q};
          mem_req_o.wdata = first_q;
          old_d    = v;
          r_d      = '0;
          c_d      = '0;
          issue_d  = 1'b1;
          pend_d   = 1'b0;
          status_d = mrmg_pkg::STAT_OK;
          state_d  = S_REL;
        end
      end
      S_REL: begin
        // read one cell ahead while the previous one is written back
        if (pend_q && v == old_q) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = pend_addr_q;
          mem_req_o.wdata = first_q;
        end
        if (issue_q) begin
          mem_req_o.raddr = {r_q, c_q};
          pend_d      = 1'b1;
          pend_addr_d = {r_q, c_q};
          if (last_col) begin
            c_d = '0;
            if (last_row) begin
              issue_d = 1'b0;
            end else begin
              r_d = r_q + CW'(1);
            end
          end else begin
            c_d = c_q + CW'(1);
          end
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            cnt_d   = cnt_q - LW'(1);
            state_d = S_FIN_RD;
          end
        end
      end
      S_FIN_RD: begin
        mem_req_o.raddr = {row_q, col_q};
        state_d = S_FIN_CHK;
      end
      S_FIN_CHK: begin
        label_d = in_grid ? v : '0;
        if (op_q == mrmg_pkg::OP_READ && !in_grid) begin
          status_d = mrmg_pkg::STAT_BAD;
        end
        state_d = S_RESULT;
      end
      S_RESULT: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= '0;
      row_q       <= '0;
      col_q       <= '0;
      r_q         <= '0;
      c_q         <= '0;
      side_q      <= '0;
      grid_side_q <= CW'(11);
      k_q         <= '0;
      first_q     <= '0;
      old_q       <= '0;
      next_q      <= '0;
      cnt_q       <= '0;
      label_q     <= '0;
      issue_q     <= 1'b0;
      pend_q      <= 1'b0;
      pend_addr_q <= '0;
      ready_q     <= 1'b0;
      status_q    <= mrmg_pkg::STAT_OK;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      row_q       <= row_d;
      col_q       <= col_d;
      r_q         <= r_d;
      c_q         <= c_d;
      side_q      <= side_d;
      grid_side_q <= grid_side_d;
      k_q         <= k_d;
      first_q     <= first_d;
      old_q       <= old_d;
      next_q      <= next_d;
      cnt_q       <= cnt_d;
      label_q     <= label_d;
      issue_q     <= issue_d;
      pend_q      <= pend_d;
      pend_addr_q <= pend_addr_d;
      ready_q     <= ready_d;
      status_q    <= status_d;
    end
  end

  assign in_ready_o      = (state_q == S_IDLE);
  assign res_valid_o     = (state_q == S_RESULT);
  assign res_o.status    = status_q;
  assign res_o.label     = label_q;
  assign res_o.regions   = cnt_q;
  assign res_o.finished  = ready_q && (cnt_q <= LW'(1));

  // writes happen only while preparing, opening a wall or relabeling
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req_o.we |-> (state_q == S_PREP || state_q == S_TRY_CHK || state_q == S_REL))
    else $error("grid write outside a writing phase");

  // outside a prepare the region count only holds or drops by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_PREP) |=> (cnt_q == $past(cnt_q) || cnt_q == $past(cnt_q) - LW'(1)))
    else $error("region count moved by more than one");

  // once prepared the grid stays prepared
  assert property (@(posedge clk_i) disable iff (!rst_ni) !$fell(ready_q))
    else $error("grid ready flag dropped");

  // a merge always replaces a real label with a different one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_REL) |-> (old_q != '0 && first_q != '0 && old_q != first_q))
    else $error("relabel with bad labels");

endmodule

// File: src/maze_region_merge_generator.sv
// read and bad requests go from accept through the final read and check states to the result
// prepare: one grid write per cycle over all side*side cells
// merging try: bounded by the relabel sweep over the side*side cells
//   of the grid; a try without merge stops after the neighbor reads
// one request at a time; the next is accepted once the result is handed over
// async active-low reset clears control and sets grid_side to 11, no grid
module maze_region_merge_generator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mrmg_pkg::COORD_W-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    operation_i,
  input  logic [mrmg_pkg::COORD_W-1:0]  row_i,
  input  logic [mrmg_pkg::COORD_W-1:0]  col_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    status_o,
  output logic [mrmg_pkg::LABEL_W-1:0]  cell_label_o,
  output logic [mrmg_pkg::LABEL_W-1:0]  regions_left_o,
  output logic                          finished_o
);

  mrmg_pkg::mem_req_t           mem_req;
  logic [mrmg_pkg::LABEL_W-1:0] mem_rdata;
  mrmg_pkg::result_t            res, out_q;
  logic                         res_valid, res_ready, out_valid_q;

  mrmg_grid_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  mrmg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .row_i       (row_i),
    .col_i       (col_i),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // output register, refilled as soon as the old result is taken
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_q.status;
  assign cell_label_o   = out_q.label;
  assign regions_left_o = out_q.regions;
  assign finished_o     = out_q.finished;

endmodule

// File: tb/maze_region_merge_generator_tb.sv
module maze_region_merge_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED  = 2'd3;
  localparam int         IDLE_LIMIT = 40000;
  localparam int         DRAIN_CYCLES = 20;
  localparam int         SHOWN_MISMATCHES = 10;
  localparam int         CW = mrmg_pkg::COORD_W;
  localparam int         LW = mrmg_pkg::LABEL_W;

  typedef struct packed {
    logic [1:0]    op;
    logic [CW-1:0] row;
    logic [CW-1:0] col;
  } cell_req_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_SLOW} rx_mode_e;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          cfg_we = 1'b0;
  logic [CW-1:0] cfg_wdata = '0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  logic [1:0]    operation = '0;
  logic [CW-1:0] row = '0;
  logic [CW-1:0] col = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic [1:0]    status;
  logic [LW-1:0] cell_label;
  logic [LW-1:0] regions_left;
  logic          finished;

  // model of the label grid and its control state
  logic [LW-1:0] label_grid_q [0:mrmg_pkg::DEPTH-1];
  int unsigned   region_cnt_q = 0;
  bit            grid_prepared_q = 1'b0;
  int unsigned   active_side_q = 0;
  logic [CW-1:0] side_reg_q = 6'd11;

  cell_req_t         pending_reqs[$];
  mrmg_pkg::result_t results_due[$];

  logic     req_taken = 1'b0;
  int       gap_left = 0;
  int       burst_left = 0;
  rx_mode_e rx_mode = RX_OPEN;
  int       rx_left = 0;
  int       mismatches = 0;
  int       idle_cycles = 0;

  maze_region_merge_generator u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .operation_i    (operation),
    .row_i          (row),
    .col_i          (col),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .status_o       (status),
    .cell_label_o   (cell_label),
    .regions_left_o (regions_left),
    .finished_o     (finished)
  );

  always #10 clk = ~clk;

  function automatic mrmg_pkg::result_t predict_cell_request(input logic [1:0] op,
                                                             input logic [CW-1:0] r,
                                                             input logic [CW-1:0] c);
    mrmg_pkg::result_t res;
    mrmg_pkg::status_e st;
    int unsigned       rr;
    int unsigned       cc;
    int unsigned       next_lbl;
    int unsigned       half;
    logic [CW-1:0]     nr;
    logic [CW-1:0]     nc;
    logic [LW-1:0]     first_lbl;
    logic [LW-1:0]     nb_lbl;
    logic              merged;
    logic              in_grid;
    st = mrmg_pkg::STAT_BAD;
    case (op)
      mrmg_pkg::OP_PREPARE: begin
        if (side_reg_q < 3 || !side_reg_q[0] || side_reg_q > mrmg_pkg::SIDE_MAX) begin
          st = mrmg_pkg::STAT_BAD;
        end else begin
          next_lbl = 1;
          for (rr = 0; rr < side_reg_q; rr++) begin
            for (cc = 0; cc < side_reg_q; cc++) begin
              if (rr[0] && cc[0]) begin
                label_grid_q[rr * 64 + cc] = next_lbl[LW-1:0];
                next_lbl++;
              end else begin
                label_grid_q[rr * 64 + cc] = '0;
              end
            end
          end
          half = (side_reg_q - 1) / 2;
          region_cnt_q = (half * half) & 10'h3ff;
          active_side_q = side_reg_q;
          grid_prepared_q = 1'b1;
          st = mrmg_pkg::STAT_OK;
        end
      end
      mrmg_pkg::OP_TRY: begin
        if (!grid_prepared_q) begin
          st = mrmg_pkg::STAT_BAD;
        end else if (region_cnt_q <= 1) begin
          st = mrmg_pkg::STAT_FINISHED;
        end else if (r < 1 || c < 1 || r + 1 >= active_side_q || c + 1 >= active_side_q) begin
          st = mrmg_pkg::STAT_BAD;
        end else if (label_grid_q[{r, c}] != 0) begin
          st = mrmg_pkg::STAT_NO_MERGE;
        end else begin
          st = mrmg_pkg::STAT_NO_MERGE;
          first_lbl = '0;
          merged = 1'b0;
          // neighbors in order down, up, right, left
          for (int k = 0; k < 4; k++) begin
            if (!merged) begin
              nr = r;
              nc = c;
              case (k)
                0: nr = r + 6'd1;
                1: nr = r - 6'd1;
                2: nc = c + 6'd1;
                default: nc = c - 6'd1;
              endcase
              nb_lbl = label_grid_q[{nr, nc}];
              if (nb_lbl != 0) begin
                if (first_lbl == 0 || first_lbl == nb_lbl) begin
                  first_lbl = nb_lbl;
                end else begin
                  label_grid_q[{r, c}] = first_lbl;
                  for (rr = 0; rr < active_side_q; rr++) begin
                    for (cc = 0; cc < active_side_q; cc++) begin
                      if (label_grid_q[rr * 64 + cc] == nb_lbl) begin
                        label_grid_q[rr * 64 + cc] = first_lbl;
                      end
                    end
                  end
                  region_cnt_q--;
                  st = mrmg_pkg::STAT_OK;
                  merged = 1'b1;
                end
              end
            end
          end
        end
      end
      mrmg_pkg::OP_READ: st = mrmg_pkg::STAT_OK;
      default: st = mrmg_pkg::STAT_BAD;
    endcase
    in_grid = grid_prepared_q && r < active_side_q && c < active_side_q;
    if (op == mrmg_pkg::OP_READ && !in_grid) begin
      st = mrmg_pkg::STAT_BAD;
    end
    res.status   = st;
    res.label    = in_grid ? label_grid_q[{r, c}] : '0;
    res.regions  = region_cnt_q[LW-1:0];
    res.finished = grid_prepared_q && region_cnt_q <= 1;
    return res;
  endfunction

  // sender: bursts of requests with random gaps, valid held until taken
  always @(negedge clk) begin : feed_requests
    logic      next_valid;
    cell_req_t nxt;
    next_valid = in_valid;
    if (!rst_n) begin
      next_valid = 1'b0;
    end else if (!in_valid || req_taken) begin
      next_valid = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_reqs.size() > 0) begin
        nxt = pending_reqs.pop_front();
        operation <= nxt.op;
        row <= nxt.row;
        col <= nxt.col;
        next_valid = 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 7);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
    in_valid <= next_valid;
  end

  // receiver: stall pattern switches between open, coin flip and slow
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 2));
      rx_left = $urandom_range(16, 80);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RX_OPEN: out_ready <= 1'b1;
      RX_COIN: out_ready <= $urandom_range(0, 1);
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin : check_results
    mrmg_pkg::result_t want;
    logic              busy;
    if (rst_n) begin
      busy = 1'b0;
      if (cfg_we) begin
        side_reg_q = cfg_wdata;
      end
      if (in_valid && in_ready) begin
        results_due.push_back(predict_cell_request(operation, row, col));
        busy = 1'b1;
      end
      req_taken <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        busy = 1'b1;
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= SHOWN_MISMATCHES) begin
            $display("unexpected result: status %0d label %0d regions %0d finished %0d",
                     status, cell_label, regions_left, finished);
          end
        end else begin
          want = results_due.pop_front();
          if (status !== want.status || cell_label !== want.label ||
              regions_left !== want.regions || finished !== want.finished) begin
            mismatches++;
            if (mismatches <= SHOWN_MISMATCHES) begin
              $display("mismatch: expected status %0d label %0d regions %0d finished %0d,",
                       want.status, want.label, want.regions, want.finished);
              $display("          got      status %0d label %0d regions %0d finished %0d",
                       status, cell_label, regions_left, finished);
            end
          end
        end
      end
      idle_cycles = busy ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic push_req(input logic [1:0] op, input int r, input int c);
    cell_req_t req;
    req.op = op;
    req.row = r[CW-1:0];
    req.col = c[CW-1:0];
    pending_reqs.push_back(req);
  endtask

  task automatic wait_idle();
    @(posedge clk);
    while (pending_reqs.size() != 0 || results_due.size() != 0 || in_valid) begin
      @(posedge clk);
    end
  endtask

  task automatic write_side(input int value);
    wait_idle();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = value[CW-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // mostly tries on walls between rooms, the rest reads and noise
  task automatic queue_random_requests(input int count);
    int s;
    int pick;
    int r;
    int c;
    for (int i = 0; i < count; i++) begin
      s = grid_prepared_q ? int'(active_side_q) : 11;
      pick = $urandom_range(0, 99);
      if (pick < 65 && s >= 5) begin
        r = $urandom_range(1, s - 2);
        if (r % 2 == 1) begin
          c = 2 * $urandom_range(1, (s - 3) / 2);
        end else begin
          c = 2 * $urandom_range(0, (s - 3) / 2) + 1;
        end
        push_req(mrmg_pkg::OP_TRY, r, c);
      end else if (pick < 75) begin
        push_req(mrmg_pkg::OP_TRY, $urandom_range(0, 63), $urandom_range(0, 63));
      end else if (pick < 88) begin
        if ($urandom_range(0, 1) == 0) begin
          push_req(mrmg_pkg::OP_READ, $urandom_range(0, s - 1), $urandom_range(0, s - 1));
        end else begin
          push_req(mrmg_pkg::OP_READ, $urandom_range(0, 63), $urandom_range(0, 63));
        end
      end else if (pick < 94) begin
        push_req(mrmg_pkg::OP_PREPARE, $urandom_range(0, 63), $urandom_range(0, 63));
      end else begin
        push_req(OP_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63));
      end
    end
  endtask

  initial begin
    int side;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // nothing prepared yet, then the reset side of 11
    push_req(mrmg_pkg::OP_READ, 0, 0);
    push_req(mrmg_pkg::OP_TRY, 2, 1);
    push_req(OP_UNUSED, 63, 63);
    push_req(mrmg_pkg::OP_PREPARE, 0, 0);
    push_req(mrmg_pkg::OP_READ, 1, 1);
    push_req(mrmg_pkg::OP_READ, 11, 0);
    push_req(mrmg_pkg::OP_READ, 63, 63);
    push_req(mrmg_pkg::OP_TRY, 0, 5);
    push_req(mrmg_pkg::OP_TRY, 10, 1);
    push_req(mrmg_pkg::OP_TRY, 1, 1);
    push_req(mrmg_pkg::OP_TRY, 2, 2);
    push_req(mrmg_pkg::OP_TRY, 1, 2);
    push_req(mrmg_pkg::OP_TRY, 1, 2);
    push_req(mrmg_pkg::OP_TRY, 2, 1);

    // rejected sides leave the grid alone
    write_side(10);
    push_req(mrmg_pkg::OP_PREPARE, 0, 0);
    write_side(1);
    push_req(mrmg_pkg::OP_PREPARE, 0, 0);
    write_side(0);
    push_req(mrmg_pkg::OP_PREPARE, 0, 0);

    // smallest grid is finished at once
    write_side(3);
    push_req(mrmg_pkg::OP_PREPARE, 0, 0);
    push_req(mrmg_pkg::OP_TRY, 1, 2);
    push_req(mrmg_pkg::OP_READ, 1, 1);

    write_side(63);
    push_req(mrmg_pkg::OP_PREPARE, 63, 63);
    push_req(mrmg_pkg::OP_TRY, 1, 2);
    push_req(mrmg_pkg::OP_TRY, 61, 62);
    push_req(mrmg_pkg::OP_TRY, 60, 61);
    push_req(mrmg_pkg::OP_READ, 62, 62);
    push_req(mrmg_pkg::OP_READ, 63, 0);
    push_req(mrmg_pkg::OP_READ, 1, 61);

    for (int p = 0; p < 6; p++) begin
      if ($urandom_range(0, 9) == 0) begin
        side = 2 * $urandom_range(0, 31);
      end else begin
        side = 2 * $urandom_range(2, 7) + 1;
      end
      write_side(side);
      push_req(mrmg_pkg::OP_PREPARE, $urandom_range(0, 63), $urandom_range(0, 63));
      queue_random_requests(22);
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: sim.f
src/mrmg_pkg.sv
src/mrmg_grid_mem.sv
src/mrmg_ctrl.sv
src/maze_region_merge_generator.sv
tb/maze_region_merge_generator_tb.sv
